// ----- sv/assert_macros.svh -----
// -----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions, sampled on clock and
// disabled while reset is high.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ----- sv/md5_pkg.sv -----
// -----------------------------------------------------------------------------
// MD5 package
// Types, round constants and small helper functions for the MD5 digest block.
// -----------------------------------------------------------------------------
package md5_pkg;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned ROUND_W  = 6;
   localparam int unsigned FILL_W   = 6;
   localparam int unsigned LEN_W    = 64;
   localparam int unsigned BLOCK_WORDS = 16;

   localparam logic [WORD_W-1:0] INIT_A = 32'h67452301;
   localparam logic [WORD_W-1:0] INIT_B = 32'hefcdab89;
   localparam logic [WORD_W-1:0] INIT_C = 32'h98badcfe;
   localparam logic [WORD_W-1:0] INIT_D = 32'h10325476;

   localparam logic [7:0]        PAD_BYTE    = 8'h80;
   // Once the marker lands at byte 56 or later, the length needs a block of its own.
   localparam logic [FILL_W-1:0] LEN_LIMIT   = 6'd56;
   localparam logic [3:0]        LEN_LO_WORD = 4'd14;
   localparam logic [3:0]        LEN_HI_WORD = 4'd15;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LEN,
      ST_ROUND,
      ST_ADD,
      ST_OUT
   } state_type;

   // What follows once a compression has been folded into the chaining words.
   typedef enum logic [1:0] {
      NEXT_IDLE,
      NEXT_PAD,
      NEXT_LEN,
      NEXT_OUT
   } next_job_type;

   localparam logic [WORD_W-1:0] SINE_TAB [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] SHIFT_TAB [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                                input logic [4:0] s);
      logic [2*WORD_W-1:0] dbl;
      dbl = {x, x} << s;
      return dbl[2*WORD_W-1:WORD_W];
   endfunction

endpackage

// ----- sv/md5_message_digest.sv -----
// -----------------------------------------------------------------------------
// MD5 message digest
// Takes a message one byte per beat and returns its MD5 digest as four beats.
// -----------------------------------------------------------------------------
// The block accepts one byte per beat while it is idle; a byte that does not
// complete a 64-byte block is only stored. The byte that completes a block
// starts the single shared round unit, which runs the 64 MD5 rounds at one
// round per cycle and then adds the result into the chaining words; such a
// beat holds req_tready low until that add is done. The beat with req_tlast
// set goes through a padding step and one compression before the digest is
// offered. When fewer than 9 bytes of room remain in the last block, the
// length goes into a block of its own, which costs a length step and a second
// compression. A final beat whose byte completes a block first compresses
// that block. The digest goes out as four beats, word A first, rsp_tlast on
// word D. The block is ready for the next message after the fourth beat is
// taken.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module md5_message_digest
   import md5_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Input channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] byte_present
   input  logic        req_tlast,   // end_of_message
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [1:0]  rsp_tuser,   // [1:0] word_number
   output logic        rsp_tlast    // last_word
);

   state_type                state_ff, state_in;
   next_job_type             job_ff, job_in;
   logic [ROUND_W-1:0]       round_ff, round_in;
   logic [1:0]               word_ff, word_in;
   logic [FILL_W-1:0]        fill_ff, fill_in;
   logic [LEN_W-1:0]         bitlen_ff, bitlen_in;
   logic [WORD_W-1:0]        chain_ff [4];
   logic [WORD_W-1:0]        chain_in [4];
   logic [WORD_W-1:0]        buffer_ff [BLOCK_WORDS];
   logic [WORD_W-1:0]        buffer_in [BLOCK_WORDS];
   logic [WORD_W-1:0]        a_ff, b_ff, c_ff, d_ff;
   logic [WORD_W-1:0]        a_in, b_in, c_in, d_in;

   logic                     req_fire, rsp_fire;
   logic [WORD_W-1:0]        f_mix, t_sum;
   logic [3:0]               g_idx, r_lo;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign r_lo     = round_ff[3:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser && fill_ff == '1) begin
                  state_in = ST_ROUND;
                  job_in   = req_tlast ? NEXT_PAD : NEXT_IDLE;
               end else if (req_tlast) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            state_in = ST_ROUND;
            job_in   = (fill_ff >= LEN_LIMIT) ? NEXT_LEN : NEXT_OUT;
         end
         ST_LEN: begin
            state_in = ST_ROUND;
            job_in   = NEXT_OUT;
         end
         ST_ROUND: begin
            if (round_ff == '1) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            unique case (job_ff)
               NEXT_IDLE: state_in = ST_IDLE;
               NEXT_PAD:  state_in = ST_PAD;
               NEXT_LEN:  state_in = ST_LEN;
               NEXT_OUT:  state_in = ST_OUT;
               default:   state_in = ST_IDLE;
            endcase
         end
         ST_OUT: begin
            if (rsp_fire && word_ff == 2'd3) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_OUT);
      rsp_tdata  = chain_ff[word_ff];
      rsp_tuser  = word_ff;
      rsp_tlast  = (word_ff == 2'd3);
   end

   // Round function of the shared unit.
   always_comb begin
      unique case (round_ff[5:4])
         2'd0: begin
            f_mix = (b_ff & c_ff) | (~b_ff & d_ff);
            g_idx = r_lo;
         end
         2'd1: begin
            f_mix = (d_ff & b_ff) | (~d_ff & c_ff);
            g_idx = (r_lo << 2) + r_lo + 4'd1;
         end
         2'd2: begin
            f_mix = b_ff ^ c_ff ^ d_ff;
            g_idx = (r_lo << 1) + r_lo + 4'd5;
         end
         default: begin
            f_mix = c_ff ^ (b_ff | ~d_ff);
            g_idx = (r_lo << 3) - r_lo;
         end
      endcase
      t_sum = a_ff + f_mix + SINE_TAB[round_ff] + buffer_ff[g_idx];
   end

   // Datapath next values.
   always_comb begin
      fill_in   = fill_ff;
      bitlen_in = bitlen_ff;
      chain_in  = chain_ff;
      buffer_in = buffer_ff;
      word_in   = word_ff;
      round_in  = '0;
      a_in      = chain_ff[0];
      b_in      = chain_ff[1];
      c_in      = chain_ff[2];
      d_in      = chain_ff[3];

      unique case (state_ff)
         ST_IDLE: begin
            // The buffer is all zero past the fill point, so a lane write is enough.
            if (req_fire && req_tuser) begin
               buffer_in[fill_ff[5:2]][fill_ff[1:0]*8 +: 8] = req_tdata;
               fill_in   = fill_ff + 1'b1;
               bitlen_in = bitlen_ff + LEN_W'(8);
            end
         end
         ST_PAD: begin
            buffer_in[fill_ff[5:2]][fill_ff[1:0]*8 +: 8] = PAD_BYTE;
            if (fill_ff < LEN_LIMIT) begin
               buffer_in[LEN_LO_WORD] = bitlen_ff[31:0];
               buffer_in[LEN_HI_WORD] = bitlen_ff[63:32];
            end
         end
         ST_LEN: begin
            buffer_in[LEN_LO_WORD] = bitlen_ff[31:0];
            buffer_in[LEN_HI_WORD] = bitlen_ff[63:32];
         end
         ST_ROUND: begin
            a_in     = d_ff;
            d_in     = c_ff;
            c_in     = b_ff;
            b_in     = b_ff + rotl32(t_sum, SHIFT_TAB[{round_ff[5:4], round_ff[1:0]}]);
            round_in = round_ff + 1'b1;
         end
         ST_ADD: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
            for (int i = 0; i < BLOCK_WORDS; i++) begin
               buffer_in[i] = '0;
            end
         end
         ST_OUT: begin
            if (rsp_fire) begin
               word_in = word_ff + 1'b1;
               if (word_ff == 2'd3) begin
                  chain_in[0] = INIT_A;
                  chain_in[1] = INIT_B;
                  chain_in[2] = INIT_C;
                  chain_in[3] = INIT_D;
                  fill_in     = '0;
                  bitlen_in   = '0;
               end
            end
         end
         default: begin
            word_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         job_ff      <= NEXT_IDLE;
         round_ff    <= '0;
         word_ff     <= '0;
         fill_ff     <= '0;
         bitlen_ff   <= '0;
         chain_ff[0] <= INIT_A;
         chain_ff[1] <= INIT_B;
         chain_ff[2] <= INIT_C;
         chain_ff[3] <= INIT_D;
         for (int i = 0; i < BLOCK_WORDS; i++) begin
            buffer_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         job_ff    <= job_in;
         round_ff  <= round_in;
         word_ff   <= word_in;
         fill_ff   <= fill_in;
         bitlen_ff <= bitlen_in;
         chain_ff  <= chain_in;
         buffer_ff <= buffer_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
   end

   `ASSERT_NEVER(a_no_overlap, req_tready && rsp_tvalid, "input taken while digest pending")
   `ASSERT_ALWAYS(a_round_idle, (state_ff != ST_ROUND) |-> (round_ff == '0), "round count stale")
   `ASSERT_ALWAYS(a_round_end, (state_ff == ST_ROUND && round_ff == '1) |=> (state_ff == ST_ADD), "rounds did not end in add")
   `ASSERT_ALWAYS(a_msg_clear, (rsp_fire && rsp_tlast) |=> (fill_ff == '0 && bitlen_ff == '0), "message state not cleared")
   `ASSERT_ALWAYS(a_word_idle, (state_ff != ST_OUT) |-> (word_ff == '0), "word count stale")

endmodule

// ----- bench/md5_digest_checker.sv -----
// -----------------------------------------------------------------------------
// MD5 digest checker
// Watches both streams of the MD5 block, keeps its own running digest of the
// accepted message bytes, and compares every digest beat with the prediction.
// -----------------------------------------------------------------------------
module md5_digest_checker
   import md5_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] data_byte
   input  logic              req_tuser,   // [0] byte_present
   input  logic              req_tlast,   // end_of_message
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [WORD_W-1:0] rsp_tdata,   // [31:0] digest_word
   input  logic [1:0]        rsp_tuser,   // [1:0] word_number
   input  logic              rsp_tlast,   // last_word
   output int                mismatch_count,
   output int                words_pending,
   output int                words_checked
);

   localparam int REPORT_LIMIT = 10;

   localparam logic [31:0] CHAIN_START [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   localparam logic [31:0] ROUND_SINE [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam int ROUND_SHIFT [16] = '{
      7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
   };

   // The length field starts at byte 56; a marker at or past it spills.
   localparam logic [5:0] LENGTH_OFFSET = 6'd56;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [1:0]  word_number;
      logic        last_word;
   } digest_beat_type;

   digest_beat_type digest_queue [$];

   logic [31:0] chain_q [4];
   logic [31:0] block_words [16];
   logic [5:0]  fill_q;
   logic [63:0] bit_len_q;

   function automatic logic [31:0] rotate_left(input logic [31:0] x, input int s);
      return (x << s) | (x >> (32 - s));
   endfunction

   function automatic void clear_digest_state();
      for (int i = 0; i < 4; i++) chain_q[i] = CHAIN_START[i];
      for (int i = 0; i < 16; i++) block_words[i] = '0;
      fill_q = '0;
      bit_len_q = '0;
   endfunction

   function automatic void compress_block();
      logic [31:0] a, b, c, d, f, t;
      int g, s;
      a = chain_q[0];
      b = chain_q[1];
      c = chain_q[2];
      d = chain_q[3];
      for (int r = 0; r < 64; r++) begin
         case (r / 16)
            0: begin
               f = (b & c) | (~b & d);
               g = r;
            end
            1: begin
               f = (d & b) | (~d & c);
               g = (5 * r + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               g = (3 * r + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               g = (7 * r) % 16;
            end
         endcase
         s = ROUND_SHIFT[(r / 16) * 4 + r % 4];
         t = a + f + ROUND_SINE[r] + block_words[g];
         a = d;
         d = c;
         c = b;
         b = b + rotate_left(t, s);
      end
      chain_q[0] = chain_q[0] + a;
      chain_q[1] = chain_q[1] + b;
      chain_q[2] = chain_q[2] + c;
      chain_q[3] = chain_q[3] + d;
      for (int i = 0; i < 16; i++) block_words[i] = '0;
   endfunction

   // Bytes land little-endian within each 32-bit word of the block.
   function automatic void absorb_byte(input logic [7:0] value);
      logic [5:0] pos;
      pos = fill_q;
      block_words[pos[5:2]] = block_words[pos[5:2]] | ({24'b0, value} << {pos[1:0], 3'b000});
      fill_q = pos + 6'd1;
      bit_len_q = bit_len_q + 64'd8;
      if (fill_q == 6'd0) compress_block();
   endfunction

   function automatic void finish_digest();
      logic [5:0] pos;
      digest_beat_type beat;
      pos = fill_q;
      block_words[pos[5:2]] = block_words[pos[5:2]] | (32'h80 << {pos[1:0], 3'b000});
      if (pos >= LENGTH_OFFSET) compress_block();
      block_words[14] = bit_len_q[31:0];
      block_words[15] = bit_len_q[63:32];
      compress_block();
      for (int k = 0; k < 4; k++) begin
         beat.digest_word = chain_q[k];
         beat.word_number = 2'(k);
         beat.last_word   = (k == 3);
         digest_queue.push_back(beat);
      end
      clear_digest_state();
   endfunction

   always @(posedge clock) begin
      digest_beat_type want;
      if (reset) begin
         clear_digest_state();
         digest_queue.delete();
         mismatch_count = 0;
         words_checked = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (digest_queue.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT)
                  $display("Unexpected digest beat: word %h number %0d last %0b",
                           rsp_tdata, rsp_tuser, rsp_tlast);
               mismatch_count++;
            end else begin
               want = digest_queue.pop_front();
               words_checked++;
               if (rsp_tdata !== want.digest_word || rsp_tuser !== want.word_number ||
                   rsp_tlast !== want.last_word) begin
                  if (mismatch_count < REPORT_LIMIT)
                     $display({"Digest beat mismatch: expected word %h number %0d last %0b, ",
                               "got word %h number %0d last %0b"},
                              want.digest_word, want.word_number, want.last_word,
                              rsp_tdata, rsp_tuser, rsp_tlast);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser) absorb_byte(req_tdata);
            if (req_tlast) finish_digest();
         end
      end
      words_pending = digest_queue.size();
   end

endmodule

// ----- bench/tb_top.sv -----
// -----------------------------------------------------------------------------
// MD5 message digest testbench
// Streams messages of assorted lengths into the digest block, a few chosen by
// hand and the rest random, with bursty input and a stalling receiver, and
// lets the checker compare every digest word.
// -----------------------------------------------------------------------------
module tb_top;

   localparam int RANDOM_BEATS    = 90;
   localparam int DRAIN_CYCLES    = 150;
   localparam int WATCHDOG_LIMIT  = 4000;

   typedef enum int {
      RECV_OPEN,
      RECV_COIN,
      RECV_SLOW
   } recv_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] data_byte
   logic        req_tuser = 1'b0; // [0] byte_present
   logic        req_tlast = 1'b0; // end_of_message
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] digest_word
   logic [1:0]  rsp_tuser;        // [1:0] word_number
   logic        rsp_tlast;        // last_word

   int mismatch_count;
   int words_pending;
   int words_checked;

   int burst_left = 0;
   int counted_beats = 0;
   int message_count = 0;
   int message_bytes = 0;
   int long_count = 0;
   int spill_count = 0;
   int idle_cycles = 0;

   recv_mode_type recv_mode = RECV_OPEN;
   int recv_left = 0;

   md5_message_digest i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   md5_digest_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending),
      .words_checked  (words_checked)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // The receiver switches between open, coin-flip and mostly stalled stretches.
   always @(negedge clock) begin
      if (recv_left == 0) begin
         recv_mode = recv_mode_type'($urandom_range(0, 2));
         recv_left = $urandom_range(8, 40);
      end else begin
         recv_left--;
      end
      case (recv_mode)
         RECV_OPEN: rsp_tready <= 1'b1;
         RECV_COIN: rsp_tready <= 1'($urandom_range(0, 1));
         default:   rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Holds the beat until it is taken; the gap before the next burst follows.
   task automatic send_beat(input logic [7:0] value, input logic present, input logic last);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= present;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (present) message_bytes++;
      if (present || last) counted_beats++;
      if (last) begin
         message_count++;
         if (message_bytes >= 64) long_count++;
         if (message_bytes % 64 >= 56) spill_count++;
         message_bytes = 0;
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(0, 11);
      end
   endtask

   task automatic wait_for_digests();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (words_pending != 0);
   endtask

   task automatic send_message(input int msg_len, input logic byte_on_last);
      int body;
      body = (byte_on_last && msg_len > 0) ? msg_len - 1 : msg_len;
      for (int i = 0; i < body; i++) begin
         if ($urandom_range(0, 7) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
         send_beat(8'($urandom), 1'b1, 1'b0);
      end
      send_beat(8'($urandom), byte_on_last && msg_len > 0, 1'b1);
   endtask

   initial begin
      int msg_len;
      int random_start;
      int budget;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty message, then single-byte messages at both byte extremes.
      send_beat(8'hff, 1'b0, 1'b1);
      send_beat(8'h00, 1'b1, 1'b1);
      send_beat(8'hff, 1'b1, 1'b1);
      // Ignored beats before and inside a message, closed by an empty final beat.
      send_beat(8'h3c, 1'b0, 1'b0);
      send_beat(8'ha5, 1'b1, 1'b0);
      send_beat(8'hc3, 1'b0, 1'b0);
      send_beat(8'h5a, 1'b1, 1'b0);
      send_beat(8'h00, 1'b0, 1'b1);
      // "abc", with the last byte riding on the final beat.
      send_beat(8'h61, 1'b1, 1'b0);
      send_beat(8'h62, 1'b1, 1'b0);
      send_beat(8'h63, 1'b1, 1'b1);
      wait_for_digests();

      // Mostly short messages; some cross the length field or a whole block.
      random_start = counted_beats;
      while (counted_beats - random_start < RANDOM_BEATS) begin
         budget = RANDOM_BEATS - (counted_beats - random_start);
         if ($urandom_range(0, 4) == 0)
            msg_len = $urandom_range(52, 72);
         else
            msg_len = $urandom_range(0, 10);
         if (msg_len > budget) msg_len = budget;
         send_message(msg_len, 1'($urandom_range(0, 1)));
         if ($urandom_range(0, 4) == 0) wait_for_digests();
      end

      wait_for_digests();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d messages in %0d beats; %0d filled a whole block,",
               message_count, counted_beats, long_count);
      $display("%0d spilled the length field into an extra block.", spill_count);
      $display("Compared %0d digest words, %0d mismatched.", words_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
